// ----- rtl/core/bdq_pkg.sv -----
`default_nettype none
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;
  localparam int CAP_W         = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] peek_value;
    logic [OCC_W-1:0]         occupancy;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/bdq_controller.sv -----
`default_nettype none
module bdq_controller
  import bdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  output ctl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  assign busy        = (state == ST_EXEC);
  assign done        = (state == ST_RESP);
  assign cmd.capture = start && !busy;
  assign cmd.execute = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bdq_datapath.sv -----
`default_nettype none
module bdq_datapath
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_cmd_t         cmd,
  input  wire in_word_t         request,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  output out_word_t             result
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] PEEK_ZERO = 2'd0;
  localparam logic [1:0] PEEK_ONES = 2'd1;
  localparam logic [1:0] PEEK_DATA = 2'd2;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]         capacity;
  logic [PW-1:0]            front;
  logic [PW-1:0]            front_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [KIND_W-1:0]        op_kind;
  logic [WORD_W-1:0]        op_value;
  logic [WORD_W-1:0]        rdata;
  logic [STATUS_W-1:0]      res_status;
  logic [STATUS_W-1:0]      status_next;
  logic [1:0]               peek_sel;
  logic [1:0]               peek_sel_next;

  logic [LW-1:0] limit;
  logic          full;
  logic          empty;
  logic [SW-1:0] rear_sum;
  logic [SW-1:0] last_sum;
  logic [PW-1:0] rear_idx;
  logic [PW-1:0] last_idx;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] front_inc;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] rd_addr;

  always_comb begin
    limit = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
    full  = LW'(count) >= limit;
    empty = (count == '0);

    rear_sum = SW'(front) + SW'(count);
    if (rear_sum >= SW'(DEPTH)) rear_sum = rear_sum - SW'(DEPTH);
    rear_idx = rear_sum[PW-1:0];

    last_sum = SW'(front) + SW'(count) - SW'(1);
    if (last_sum >= SW'(DEPTH)) last_sum = last_sum - SW'(DEPTH);
    last_idx = last_sum[PW-1:0];

    front_dec = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);
    front_inc = (front == PW'(DEPTH - 1)) ? '0 : front + PW'(1);
  end

  always_comb begin
    front_next    = front;
    count_next    = count;
    status_next   = STATUS_DONE;
    peek_sel_next = PEEK_ZERO;
    wr_en         = 1'b0;
    wr_addr       = rear_idx;
    rd_addr       = front;
    case (op_kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          front_next = front_dec;
          wr_addr    = front_dec;
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      KIND_PUSH_REAR: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      KIND_POP_REAR: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      KIND_PEEK_FRONT, KIND_PEEK_REAR: begin
        rd_addr = (op_kind == KIND_PEEK_REAR) ? last_idx : front;
        if (empty) begin
          status_next   = STATUS_EMPTY;
          peek_sel_next = PEEK_ONES;
        end else begin
          peek_sel_next = PEEK_DATA;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) mem[wr_addr] <= op_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= request.kind;
      op_value <= request.push_value;
    end
    if (cmd.execute) begin
      res_status <= status_next;
      peek_sel   <= peek_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      front    <= '0;
      count    <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      if (cmd.execute) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  always_comb begin
    result.status    = res_status;
    result.occupancy = OCC_W'(count);
    case (peek_sel)
      PEEK_ONES: result.peek_value = '1;
      PEEK_DATA: result.peek_value = rdata;
      default:   result.peek_value = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/bounded_double_ended_queue_core.sv -----
// A word taken in when start is high and busy low is captured, then executed while the
// controller is in its execute state; its result shows on result, marked by done for exactly
// one cycle, and the receiver cannot stall it. No new word is taken in while busy is high, but
// a new start is taken in the cycle done is high.
// Reset (rst, synchronous): empties the queue, front pointer zero, capacity 16;
// memory contents stay undefined until written.
`default_nettype none
module bounded_double_ended_queue_core
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_word_t         request,
  output logic                  done,
  output out_word_t             result,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;

  bdq_controller u_ctl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by a result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding busy cycle");

  a_full_no_peek: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_FULL) |-> (result.peek_value == '0))
    else $error("refused push carries a peek value");
`endif

endmodule
`default_nettype wire
